@@ design/pwmsd_pkg.sv @@
// Shared types, constants and the coil table for the PWM to stepper phase drive.
// Used by pwmsd_ctrl, pwmsd_dpath and pwm_to_stepper_phase_drive; no dependencies.
package pwmsd_pkg;

    localparam int TICK_US_DEF       = 100;
    localparam int STEPS_PER_REV_DEF = 200;

    localparam longint unsigned FULL_SCALE = 32768;
    localparam longint unsigned SLOW_CAP   = 300000000;
    localparam longint unsigned IVL_RESET  = 1000000;
    localparam longint unsigned US_PER_MIN = 60000000;
    localparam longint unsigned SLOW_MULT  = 1000;

    localparam int LEVEL_W     = 17;
    localparam int MAG_W       = 16;
    localparam int FRAC_W      = 16;
    localparam int SPEED_W     = 16;
    localparam int IVL_OUT_W   = 29;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd2;

    typedef struct packed {
        logic load_in;
        logic filt_mul;
        logic filt_add;
        logic den_mul;
        logic div_start;
        logic div_step;
        logic ivl_load;
        logic commit;
    } pwmsd_cmd_t;

    typedef struct packed {
        logic filter_en;
        logic div_last;
        logic out_free;
    } pwmsd_sts_t;

    function automatic logic [3:0] coil_row(input logic [1:0] ph);
        logic [3:0] row;
        case (ph)
            2'd0:    row = 4'hA;
            2'd1:    row = 4'h6;
            2'd2:    row = 4'h5;
            default: row = 4'h9;
        endcase
        return row;
    endfunction

endpackage

@@ design/pwmsd_ctrl.sv @@
// Sequencing state machine for the phase drive: filter, multiply, serial divide, commit
// (filter off: commit only). Depends on pwmsd_pkg for the command and status structs.
module pwmsd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  pwmsd_pkg::pwmsd_sts_t sts,
    output pwmsd_pkg::pwmsd_cmd_t cmd
);
    import pwmsd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_ADD  = 8'b0000_0100,
        S_DMUL = 8'b0000_1000,
        S_DSET = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_IVL  = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   in_xfer;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = sts.filter_en ? S_MUL : S_FIN;
                end
            end
            S_MUL:
            begin
                cmd.filt_mul = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                cmd.filt_add = 1'b1;
                state_next   = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.den_mul = 1'b1;
                state_next  = S_DSET;
            end
            S_DSET:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_IVL;
                end
            end
            S_IVL:
            begin
                cmd.ivl_load = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("transfer taken while an item is in flight");

    a_ivl_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IVL |-> $past(state_reg == S_DIV))
        else $error("interval load without a completed divide");

    a_fin_release: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && sts.out_free |=> state_reg == S_IDLE)
        else $error("commit did not return to idle");

endmodule

@@ design/pwmsd_dpath.sv @@
// Datapath for the phase drive: config registers, low-pass filter, speed multiply,
// restoring divider, elapsed timer, phase counter and output register. Uses pwmsd_pkg.
module pwmsd_dpath #(
    parameter int TICK_US       = pwmsd_pkg::TICK_US_DEF,
    parameter int STEPS_PER_REV = pwmsd_pkg::STEPS_PER_REV_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pwmsd_pkg::pwmsd_cmd_t                cmd,
    output pwmsd_pkg::pwmsd_sts_t                sts,
    input  logic                                 in_a,
    input  logic                                 in_b,
    input  logic                                 cfg_we,
    input  logic [pwmsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pwmsd_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [pwmsd_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import pwmsd_pkg::*;

    localparam longint unsigned UNIT     = US_PER_MIN / STEPS_PER_REV;
    localparam longint unsigned SLOW_RAW = UNIT * SLOW_MULT;
    localparam longint unsigned SLOW     = (SLOW_RAW > SLOW_CAP) ? SLOW_CAP : SLOW_RAW;
    localparam longint unsigned NUM      = UNIT * FULL_SCALE;
    localparam int NUM_W  = $clog2(NUM + 1);
    localparam int IVL_W  = $clog2(SLOW + 1);
    localparam int ELAP_W = $clog2(SLOW + TICK_US + 1);
    localparam int DEN_W  = SPEED_W + MAG_W;
    localparam int CNT_W  = $clog2(NUM_W + 1);
    localparam int PROD_W = LEVEL_W + 1 + FRAC_W + 1;

    logic [FRAC_W-1:0]         smooth_reg;
    logic                      filt_en_reg;
    logic [SPEED_W-1:0]        speed_reg;

    logic signed [LEVEL_W-1:0] level_reg;
    logic [IVL_W-1:0]          ivl_reg;
    logic [ELAP_W-1:0]         elap_reg;
    logic [1:0]                phase_reg;

    logic                      a_reg, b_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [DEN_W-1:0]          rem_reg;
    logic [NUM_W-1:0]          quo_reg;
    logic [CNT_W-1:0]          cnt_reg;

    logic                      out_valid_reg;
    logic [3:0]                out_coil_reg;
    logic [1:0]                out_phase_reg;
    logic                      out_step_reg;
    logic [MAG_W-1:0]          out_mag_reg;
    logic [IVL_W-1:0]          out_ivl_reg;

    logic signed [LEVEL_W:0]   target;
    logic signed [LEVEL_W:0]   diff;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [LEVEL_W+1:0] level_sum;
    logic [LEVEL_W-1:0]        level_abs;
    logic [MAG_W-1:0]          mag;
    logic [DEN_W:0]            rem_shift;
    logic [DEN_W+1:0]          trial;
    logic                      q_bit;
    logic [ELAP_W-1:0]         elap_inc;
    logic                      restart;
    logic [1:0]                phase_next;
    logic                      step_next;

    always_comb
    begin
        if (a_reg && !b_reg)
        begin
            target = (LEVEL_W+1)'(FULL_SCALE);
        end
        else if (!a_reg && b_reg)
        begin
            target = -(LEVEL_W+1)'(FULL_SCALE);
        end
        else
        begin
            target = '0;
        end
    end

    assign diff      = target - {level_reg[LEVEL_W-1], level_reg};
    assign prod_next = diff * $signed({1'b0, smooth_reg});
    assign level_sum = {{2{level_reg[LEVEL_W-1]}}, level_reg}
                     + prod_reg[PROD_W-1:FRAC_W];
    assign level_abs = level_reg[LEVEL_W-1] ? LEVEL_W'(-level_reg) : LEVEL_W'(level_reg);
    assign mag       = level_abs[MAG_W-1:0];

    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, den_reg};
    assign q_bit     = !trial[DEN_W+1];

    assign elap_inc  = elap_reg + ELAP_W'(TICK_US);
    assign restart   = elap_inc > ELAP_W'(ivl_reg);

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = 1'b0;
        if (restart && (level_reg != '0))
        begin
            step_next  = 1'b1;
            phase_next = level_reg[LEVEL_W-1] ? phase_reg - 2'd1 : phase_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg  <= FRAC_W'(7);
            filt_en_reg <= 1'b1;
            speed_reg   <= SPEED_W'(60);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SMOOTH:    smooth_reg  <= cfg_data[FRAC_W-1:0];
                CFG_FILTER_EN: filt_en_reg <= cfg_data[0];
                CFG_MAX_SPEED: speed_reg   <= cfg_data[SPEED_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            ivl_reg       <= IVL_W'(IVL_RESET);
            elap_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.filt_add)
            begin
                level_reg <= level_sum[LEVEL_W-1:0];
            end
            if (cmd.ivl_load)
            begin
                if ((den_reg == '0) || (quo_reg > NUM_W'(SLOW)))
                begin
                    ivl_reg <= IVL_W'(SLOW);
                end
                else
                begin
                    ivl_reg <= quo_reg[IVL_W-1:0];
                end
            end
            if (cmd.commit)
            begin
                elap_reg      <= restart ? '0 : elap_inc;
                phase_reg     <= phase_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg <= in_a;
            b_reg <= in_b;
        end
        if (cmd.filt_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.den_mul)
        begin
            den_reg <= DEN_W'(speed_reg) * DEN_W'(mag);
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= NUM_W'(NUM);
            cnt_reg <= CNT_W'(NUM_W);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= q_bit ? trial[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (cmd.commit)
        begin
            out_coil_reg  <= coil_row(phase_next);
            out_phase_reg <= phase_next;
            out_step_reg  <= step_next;
            out_mag_reg   <= mag;
            out_ivl_reg   <= ivl_reg;
        end
    end

    assign sts.filter_en = filt_en_reg;
    assign sts.div_last  = (cnt_reg == CNT_W'(1));
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, IVL_OUT_W'(out_ivl_reg), out_mag_reg, out_step_reg,
                       out_phase_reg, out_coil_reg};

    a_ivl_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ivl_reg <= IVL_W'(SLOW))
        else $error("step interval above slow limit");

    a_step_needs_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_step_reg |-> out_mag_reg != '0)
        else $error("step reported at zero drive level");

    a_phase_move: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && !step_next |=> $stable(phase_reg))
        else $error("phase moved without a step");

endmodule

@@ design/pwm_to_stepper_phase_drive.sv @@
// Top level of the PWM to stepper phase drive: stream ports, config port, ctrl and datapath.
// Depends on pwmsd_pkg, pwmsd_ctrl and pwmsd_dpath.
// With the filter on: filter multiply and add, speed multiply, divider setup, a restoring divide
// for the step interval (one quotient bit per cycle; NUM_W = bits of 60000000/STEPS_PER_REV*32768,
// 34 by default), interval load, then commit; with the filter off, straight to commit. Commit waits
// for a free output register, and a new item is taken only after the last one is committed.
// Reset: asynchronous, active low; level 0, interval 1000000 us, phase 0, config to defaults.
module pwm_to_stepper_phase_drive #(
    parameter int TICK_US       = pwmsd_pkg::TICK_US_DEF,
    parameter int STEPS_PER_REV = pwmsd_pkg::STEPS_PER_REV_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] in_a, [1] in_b
    input  logic [pwmsd_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [3:0] coil_bits, [5:4] phase_index, [6] step_taken, [22:7] level_magnitude,
    // [51:23] interval_now
    output logic [pwmsd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                               cfg_we,
    input  logic [pwmsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pwmsd_pkg::CFG_W-1:0]        cfg_data
);
    import pwmsd_pkg::*;

    pwmsd_cmd_t cmd;
    pwmsd_sts_t sts;

    pwmsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pwmsd_dpath #(
        .TICK_US       (TICK_US),
        .STEPS_PER_REV (STEPS_PER_REV)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_a      (s_tdata[0]),
        .in_b      (s_tdata[1]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

@@ tb/tb_top.sv @@
// Self-checking bench for pwm_to_stepper_phase_drive: a zero-level hold run, a table of
// directed ticks, then randomized drive runs under several register settings.
// Depends on pwmsd_pkg and the design sources; results are predicted by an in-bench model.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned TICK      = pwmsd_pkg::TICK_US_DEF;
    localparam longint unsigned UNIT_US   = pwmsd_pkg::US_PER_MIN /
                                            longint'(pwmsd_pkg::STEPS_PER_REV_DEF);
    localparam longint unsigned SLOW_RAW  = UNIT_US * pwmsd_pkg::SLOW_MULT;
    localparam longint unsigned SLOW_US   = (SLOW_RAW > pwmsd_pkg::SLOW_CAP) ?
                                            pwmsd_pkg::SLOW_CAP : SLOW_RAW;
    localparam logic [15:0]     COIL_ROWS = 16'h956A;
    localparam logic [pwmsd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int HOLD_TICKS  = 20;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_TICKS = 115;
    localparam int DIR_ROWS    = 24;

    typedef struct packed {
        logic [28:0] ivl;
        logic [15:0] mag;
        logic        stp;
        logic [1:0]  ph;
        logic [3:0]  coil;
    } drive_result_t;

    typedef struct packed {
        logic                              cfg_wr;
        logic [pwmsd_pkg::CFG_IDX_W-1:0]   cfg_sel;
        logic [pwmsd_pkg::CFG_W-1:0]       cfg_val;
        logic                              in_a;
        logic                              in_b;
        logic                              fixed;
        drive_result_t                     want;
    } tick_row_t;

    localparam drive_result_t AT_REST = '{29'(SLOW_US), 16'd0, 1'b0, 2'd0, 4'hA};
    localparam drive_result_t NONE    = '0;

    tick_row_t dir_rows [DIR_ROWS] = '{
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b0, 1'b0, 1'b1, AT_REST},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b1, 1'b1, 1'b1, AT_REST},
        '{1'b1, pwmsd_pkg::CFG_SMOOTH,    16'hFFFF,  1'b1, 1'b0, 1'b0, NONE},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b1, 1'b0, 1'b0, NONE},
        '{1'b1, pwmsd_pkg::CFG_MAX_SPEED, 16'hFFFF,  1'b1, 1'b0, 1'b0, NONE},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b1, 1'b0, 1'b0, NONE},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b1, 1'b0, 1'b0, NONE},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b0, 1'b1, 1'b0, NONE},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b0, 1'b1, 1'b0, NONE},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b0, 1'b1, 1'b0, NONE},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b0, 1'b0, 1'b0, NONE},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b1, 1'b1, 1'b0, NONE},
        '{1'b1, pwmsd_pkg::CFG_MAX_SPEED, 16'd0,     1'b0, 1'b1, 1'b0, NONE},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b1, 1'b0, 1'b0, NONE},
        '{1'b1, pwmsd_pkg::CFG_FILTER_EN, 16'd0,     1'b1, 1'b0, 1'b0, NONE},
        '{1'b0, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b0, 1'b1, 1'b0, NONE},
        '{1'b1, CFG_UNUSED,               16'hFFFF,  1'b0, 1'b0, 1'b0, NONE},
        '{1'b1, pwmsd_pkg::CFG_FILTER_EN, 16'hFFFE,  1'b1, 1'b1, 1'b0, NONE},
        '{1'b1, pwmsd_pkg::CFG_FILTER_EN, 16'h0001,  1'b1, 1'b0, 1'b0, NONE},
        '{1'b1, pwmsd_pkg::CFG_SMOOTH,    16'd0,     1'b0, 1'b1, 1'b0, NONE},
        '{1'b1, pwmsd_pkg::CFG_MAX_SPEED, 16'd1,     1'b1, 1'b0, 1'b0, NONE},
        '{1'b1, pwmsd_pkg::CFG_SMOOTH,    16'd1,     1'b0, 1'b1, 1'b0, NONE},
        '{1'b1, pwmsd_pkg::CFG_SMOOTH,    16'd7,     1'b1, 1'b0, 1'b0, NONE},
        '{1'b1, pwmsd_pkg::CFG_MAX_SPEED, 16'd60,    1'b0, 1'b0, 1'b0, NONE}
    };

    logic                                 clk;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [pwmsd_pkg::IN_TDATA_W-1:0]     s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [pwmsd_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                                 cfg_we;
    logic [pwmsd_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [pwmsd_pkg::CFG_W-1:0]          cfg_data;

    logic [15:0]       blend;
    logic              filt_on;
    logic [15:0]       rpm_full;
    longint            drive_lvl;
    longint unsigned   step_ivl;
    longint unsigned   since_step;
    logic [1:0]        coil_ph;

    drive_result_t     coil_due [$];
    int                bad_count;
    logic              hush;
    logic              tail_quiet;
    int                stall_left;

    pwm_to_stepper_phase_drive u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic drive_result_t drive_tick(input logic a, input logic b);
        drive_result_t     r;
        longint            tgt;
        longint            dif;
        longint unsigned   mag;
        longint unsigned   den;
        longint unsigned   quo;
        logic              stp;
        stp = 1'b0;
        if (filt_on)
        begin
            tgt = 0;
            if (a && !b)
                tgt = longint'(pwmsd_pkg::FULL_SCALE);
            else if (!a && b)
                tgt = -longint'(pwmsd_pkg::FULL_SCALE);
            dif = tgt - drive_lvl;
            drive_lvl = drive_lvl + ((dif * longint'(blend)) >>> 16);
        end
        mag = (drive_lvl < 0) ? longint'(-drive_lvl) : longint'(drive_lvl);
        if (filt_on)
        begin
            den = longint'(rpm_full) * mag;
            if (den == 0)
                step_ivl = SLOW_US;
            else
            begin
                quo = (UNIT_US * pwmsd_pkg::FULL_SCALE) / den;
                step_ivl = (quo > SLOW_US) ? SLOW_US : quo;
            end
        end
        since_step = since_step + TICK;
        if (since_step > 64'hFFFF_FFFF)
            since_step = 64'hFFFF_FFFF;
        if (since_step > step_ivl)
        begin
            since_step = 0;
            if (drive_lvl > 0)
            begin
                coil_ph = coil_ph + 2'd1;
                stp = 1'b1;
            end
            else if (drive_lvl < 0)
            begin
                coil_ph = coil_ph - 2'd1;
                stp = 1'b1;
            end
        end
        r.coil = COIL_ROWS[4*coil_ph +: 4];
        r.ph   = coil_ph;
        r.stp  = stp;
        r.mag  = mag[15:0];
        r.ivl  = step_ivl[28:0];
        return r;
    endfunction

    // Hold valid until the transfer; return at the accepting edge.
    task automatic send_tick(input logic a, input logic b, input logic fixed,
                             input drive_result_t want);
        drive_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'($urandom), b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = drive_tick(a, b);
        coil_due.push_back(fixed ? want : r);
    endtask

    task automatic tick_gap();
        if (!hush && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (coil_due.size() != 0);
    endtask

    task automatic cfg_write(input logic [pwmsd_pkg::CFG_IDX_W-1:0] sel,
                             input logic [pwmsd_pkg::CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        case (sel)
            pwmsd_pkg::CFG_SMOOTH:    blend    = val;
            pwmsd_pkg::CFG_FILTER_EN: filt_on  = val[0];
            pwmsd_pkg::CFG_MAX_SPEED: rpm_full = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drive_runs(input int n_ticks);
        int   left;
        int   run_len;
        int   mode;
        logic a;
        logic b;
        left = n_ticks;
        while (left > 0)
        begin
            mode    = $urandom_range(0, 9);
            run_len = (mode < 2) ? $urandom_range(1, 8) : $urandom_range(5, 60);
            if (run_len > left)
                run_len = left;
            if (!tail_quiet)
                hush <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0)
                settle();
            repeat (run_len)
            begin
                case (mode % 4)
                    0, 1:
                    begin
                        a = $urandom_range(0, 1);
                        b = $urandom_range(0, 1);
                    end
                    2:
                    begin
                        a = 1'b1;
                        b = 1'b0;
                    end
                    default:
                    begin
                        a = 1'b0;
                        b = 1'b1;
                    end
                endcase
                if (mode >= 8)
                begin
                    a = $urandom_range(0, 1);
                    b = a;
                end
                send_tick(a, b, 1'b0, NONE);
                tick_gap();
            end
            left = left - run_len;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!hush && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        drive_result_t want;
        drive_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = drive_result_t'(m_tdata[51:0]);
            if (coil_due.size() == 0)
            begin
                bad_count = bad_count + 1;
                if (bad_count <= 10)
                    $display("unexpected transfer: tdata %h", m_tdata);
            end
            else
            begin
                want = coil_due.pop_front();
                if (got.coil != want.coil || got.ph != want.ph || got.stp != want.stp ||
                    got.mag != want.mag || got.ivl != want.ivl)
                begin
                    bad_count = bad_count + 1;
                    if (bad_count <= 10)
                        $display({"mismatch at %0t: coil %h/%h phase %0d/%0d step %0d/%0d",
                                  " mag %0d/%0d ivl %0d/%0d (exp/act)"}, $realtime,
                                 want.coil, got.coil, want.ph, got.ph, want.stp, got.stp,
                                 want.mag, got.mag, want.ivl, got.ivl);
                end
            end
        end
    end

    initial
    begin
        #30000000;
        $display("pwm_to_stepper_phase_drive regression: fail");
        $finish;
    end

    initial
    begin
        logic [15:0] frac_set;
        logic        fen_set;
        logic [15:0] rpm_set;
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        hush       = 1'b0;
        tail_quiet = 1'b0;
        bad_count  = 0;
        blend      = 16'd7;
        filt_on    = 1'b1;
        rpm_full   = 16'd60;
        drive_lvl  = 0;
        step_ivl   = pwmsd_pkg::IVL_RESET;
        since_step = 0;
        coil_ph    = 2'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Hold level and interval at their reset values with the filter off.
        cfg_write(pwmsd_pkg::CFG_FILTER_EN, 16'd0);
        repeat (HOLD_TICKS)
        begin
            send_tick($urandom_range(0, 1), $urandom_range(0, 1), 1'b0, NONE);
            tick_gap();
        end
        settle();
        cfg_write(pwmsd_pkg::CFG_FILTER_EN, 16'd1);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].cfg_wr)
            begin
                settle();
                cfg_write(dir_rows[i].cfg_sel, dir_rows[i].cfg_val);
            end
            send_tick(dir_rows[i].in_a, dir_rows[i].in_b, dir_rows[i].fixed,
                      dir_rows[i].want);
            tick_gap();
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            frac_set = $urandom_range(0, 65535);
            fen_set  = 1'b1;
            rpm_set  = $urandom_range(100, 65535);
            case (p)
                0:
                begin
                    frac_set = 16'hFFFF;
                    rpm_set  = 16'hFFFF;
                end
                1:
                begin
                    frac_set = 16'd1;
                    rpm_set  = 16'hFFFF;
                end
                2:
                begin
                    frac_set = 16'd40000;
                    rpm_set  = 16'd3000;
                end
                4: fen_set = 1'b0;
                5:
                begin
                    frac_set = 16'd20000;
                    rpm_set  = 16'd0;
                end
                6:
                begin
                    frac_set = $urandom_range(1000, 65535);
                    rpm_set  = $urandom_range(300, 20000);
                end
                7:
                begin
                    frac_set = 16'hFFFF;
                    rpm_set  = 16'd1;
                end
                default: ;
            endcase
            settle();
            cfg_write(pwmsd_pkg::CFG_SMOOTH, frac_set);
            cfg_write(pwmsd_pkg::CFG_FILTER_EN, {15'($urandom), fen_set});
            cfg_write(pwmsd_pkg::CFG_MAX_SPEED, rpm_set);
            // Drop all idling for the final stretch.
            if (p == PHASE_COUNT - 1)
            begin
                hush       <= 1'b1;
                tail_quiet = 1'b1;
            end
            drive_runs(PHASE_TICKS);
        end

        settle();
        repeat (60) @(posedge clk);
        if (bad_count == 0 && coil_due.size() == 0)
            $display("pwm_to_stepper_phase_drive regression: pass");
        else
            $display("pwm_to_stepper_phase_drive regression: fail");
        $finish;
    end

endmodule
